// ===== rtl/hktm_pkg.sv =====
// Package: shared types and constants for the held key table with modifier replay.
`default_nettype none
package hktm_pkg;

	localparam int KEY_W     = 16;
	localparam int CAT_W     = 2;
	localparam int MOD_W     = 3;
	localparam int DEV_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	localparam logic [CAT_W-1:0] CAT_PRESSED  = 2'd0;
	localparam logic [CAT_W-1:0] CAT_RELEASED = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CTRL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FWD   = 3'd4;

	localparam logic [KEY_W-1:0] SHIFT_RST = 16'd16;
	localparam logic [KEY_W-1:0] CTRL_RST  = 16'd17;
	localparam logic [KEY_W-1:0] ALT_RST   = 16'd18;
	localparam logic [KEY_W-1:0] EMPTY_RST = 16'd0;

	localparam logic [MOD_W-1:0] MOD_SHIFT = 3'b001;
	localparam logic [MOD_W-1:0] MOD_CTRL  = 3'b010;
	localparam logic [MOD_W-1:0] MOD_ALT   = 3'b100;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	typedef struct packed {
		logic [KEY_W-1:0] shift_code;
		logic [KEY_W-1:0] ctrl_code;
		logic [KEY_W-1:0] alt_code;
		logic [KEY_W-1:0] empty_code;
		logic             forward_enable;
	} cfg_t;

	typedef struct packed {
		logic             is_mod;
		logic [MOD_W-1:0] mod_bit;
		logic [CAT_W-1:0] category;
		logic [KEY_W-1:0] key;
	} cmd_t;

endpackage
`default_nettype wire

// ===== rtl/hktm_ifs.sv =====
// Interfaces: event input, event output and configuration write channels.
`default_nettype none
interface hktm_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  device;
	logic        is_key;
	logic [1:0]  category;
	logic [15:0] key_code;

	modport source (output valid, device, is_key, category, key_code, input ready);
	modport sink   (input valid, device, is_key, category, key_code, output ready);
endinterface

interface hktm_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_category;
	logic [15:0] out_key;
	logic        replayed;
	logic [2:0]  modifiers;
	logic        last;

	modport source (output valid, out_category, out_key, replayed, modifiers, last,
		input ready);
	modport sink   (input valid, out_category, out_key, replayed, modifiers, last,
		output ready);
endinterface

interface hktm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/held_key_table_with_modifier_replay_unit.sv =====
// Top level: held key table with modifier replay.
`default_nettype none
// Key events from device 0 are classified in the front end and queued (two
// deep); all other events are accepted and dropped. A non-modifier event
// updates the held key table and is forwarded if forwarding is enabled,
// else it only updates the table. A shift, ctrl or alt event only updates
// the modifier mask while forwarding is disabled; else it walks the table
// twice, one slot per cycle unless a full slot waits on the output stage:
// releases for held keys, mask update, presses, then the forwarded event
// with last set. Results leave through a registered output stage, one per
// cycle at most. Configuration writes are always ready and take effect at
// once; write them only while no event is in flight.
module held_key_table_with_modifier_replay_unit
	import hktm_pkg::*;
#(
	parameter int TABLE_SLOTS = 8
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hktm_in_if.sink     in_evt,
	hktm_out_if.source  out_evt,
	hktm_cfg_if.sink    cfg
);

	cfg_t cfg_q;
	logic q_ready;
	logic q_push;
	cmd_t q_cmd;
	logic head_valid;
	cmd_t head_cmd;
	logic head_pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shift_code     <= SHIFT_RST;
			cfg_q.ctrl_code      <= CTRL_RST;
			cfg_q.alt_code       <= ALT_RST;
			cfg_q.empty_code     <= EMPTY_RST;
			cfg_q.forward_enable <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SHIFT: cfg_q.shift_code     <= cfg.data;
				CFG_CTRL:  cfg_q.ctrl_code      <= cfg.data;
				CFG_ALT:   cfg_q.alt_code       <= cfg.data;
				CFG_EMPTY: cfg_q.empty_code     <= cfg.data;
				CFG_FWD:   cfg_q.forward_enable <= cfg.data[0];
				default:   cfg_q                <= cfg_q;
			endcase
		end
	end

	hktm_front u_front (
		.in_evt  (in_evt),
		.cfg     (cfg_q),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_cmd   (q_cmd)
	);

	hktm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.push_ready (q_ready),
		.pop        (head_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	hktm_back #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (head_valid),
		.cmd       (head_cmd),
		.cmd_pop   (head_pop),
		.out_evt   (out_evt)
	);

endmodule
`default_nettype wire

// ===== rtl/hktm_front.sv =====
// Front end: accepts events, drops foreign ones, classifies modifiers.
`default_nettype none
module hktm_front
	import hktm_pkg::*;
(
	hktm_in_if.sink    in_evt,
	input  wire cfg_t  cfg,
	input  wire logic  q_ready,
	output logic       q_push,
	output cmd_t       q_cmd
);

	logic hit_shift;
	logic hit_ctrl;
	logic hit_alt;

	assign in_evt.ready = q_ready;

	assign hit_shift = (in_evt.key_code == cfg.shift_code);
	assign hit_ctrl  = (in_evt.key_code == cfg.ctrl_code);
	assign hit_alt   = (in_evt.key_code == cfg.alt_code);

	assign q_push = in_evt.valid && q_ready && in_evt.is_key && (in_evt.device == '0);

	always_comb begin
		q_cmd.is_mod   = hit_shift || hit_ctrl || hit_alt;
		q_cmd.category = in_evt.category;
		q_cmd.key      = in_evt.key_code;
		if (hit_shift) begin
			q_cmd.mod_bit = MOD_SHIFT;
		end else if (hit_ctrl) begin
			q_cmd.mod_bit = MOD_CTRL;
		end else begin
			q_cmd.mod_bit = MOD_ALT;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/hktm_queue.sv =====
// Command queue between front end and back end.
`default_nettype none
module hktm_queue
	import hktm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      push_ready,
	input  wire logic pop,
	output logic      head_valid,
	output cmd_t      head_cmd
);

	cmd_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (cnt_q != Q_CNT_W'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count exceeds depth");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) && !do_push |=> (cnt_q == '0))
		else $error("queue count changed without push");

endmodule
`default_nettype wire

// ===== rtl/hktm_back.sv =====
// Back end: held key table, modifier mask, replay sequencer and output register.
`default_nettype none
module hktm_back
	import hktm_pkg::*;
#(
	parameter int TABLE_SLOTS = 8
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire logic   cmd_valid,
	input  wire cmd_t   cmd,
	output logic        cmd_pop,
	hktm_out_if.source  out_evt
);

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_REL  = 4'b0010,
		ST_PRS  = 4'b0100,
		ST_FWD  = 4'b1000
	} state_t;

	state_t             state_q;
	state_t             state_n;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   idx_n;
	logic [KEY_W-1:0]   held_q [TABLE_SLOTS];
	logic [MOD_W-1:0]   mask_q;

	logic               ovalid_q;
	logic [CAT_W-1:0]   ocat_q;
	logic [KEY_W-1:0]   okey_q;
	logic               orep_q;
	logic [MOD_W-1:0]   omod_q;
	logic               olast_q;

	logic               out_free;
	logic               slot_full;
	logic               load;
	logic [CAT_W-1:0]   ld_cat;
	logic [KEY_W-1:0]   ld_key;
	logic               ld_rep;
	logic               ld_last;
	logic               do_tbl;
	logic               do_mask;
	logic [TABLE_SLOTS-1:0] sel_oh;
	logic               seen;
	logic [KEY_W-1:0]   find_key;

	assign out_free  = !ovalid_q || out_evt.ready;
	assign slot_full = (held_q[idx_q] != cfg.empty_code);

	assign out_evt.valid        = ovalid_q;
	assign out_evt.out_category = ocat_q;
	assign out_evt.out_key      = okey_q;
	assign out_evt.replayed     = orep_q;
	assign out_evt.modifiers    = omod_q;
	assign out_evt.last         = olast_q;

	// first slot holding find_key: empty slot for a press, the key for a release
	always_comb begin
		find_key = (cmd.category == CAT_PRESSED) ? cfg.empty_code : cmd.key;
		seen     = 1'b0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			sel_oh[i] = !seen && (held_q[i] == find_key);
			seen      = seen || (held_q[i] == find_key);
		end
	end

	always_comb begin
		state_n = state_q;
		idx_n   = idx_q;
		cmd_pop = 1'b0;
		load    = 1'b0;
		ld_cat  = cmd.category;
		ld_key  = cmd.key;
		ld_rep  = 1'b0;
		ld_last = 1'b1;
		do_tbl  = 1'b0;
		do_mask = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (!cmd.is_mod) begin
						if (!cfg.forward_enable) begin
							do_tbl  = 1'b1;
							cmd_pop = 1'b1;
						end else if (out_free) begin
							do_tbl  = 1'b1;
							cmd_pop = 1'b1;
							load    = 1'b1;
						end
					end else if (!cfg.forward_enable) begin
						do_mask = 1'b1;
						cmd_pop = 1'b1;
					end else begin
						state_n = ST_REL;
						idx_n   = '0;
					end
				end
			end
			ST_REL, ST_PRS: begin
				if (!slot_full || out_free) begin
					load    = slot_full;
					ld_cat  = (state_q == ST_REL) ? CAT_RELEASED : CAT_PRESSED;
					ld_key  = held_q[idx_q];
					ld_rep  = 1'b1;
					ld_last = 1'b0;
					if (idx_q == LAST_IDX) begin
						idx_n = '0;
						if (state_q == ST_REL) begin
							do_mask = 1'b1;
							state_n = ST_PRS;
						end else begin
							state_n = ST_FWD;
						end
					end else begin
						idx_n = idx_q + 1'b1;
					end
				end
			end
			ST_FWD: begin
				if (out_free) begin
					load    = 1'b1;
					cmd_pop = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			mask_q   <= '0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				held_q[i] <= EMPTY_RST;
			end
		end else begin
			state_q <= state_n;
			idx_q   <= idx_n;
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (out_evt.ready) begin
				ovalid_q <= 1'b0;
			end
			if (do_mask) begin
				if (cmd.category == CAT_PRESSED) begin
					mask_q <= mask_q | cmd.mod_bit;
				end else if (cmd.category == CAT_RELEASED) begin
					mask_q <= mask_q & ~cmd.mod_bit;
				end
			end
			if (do_tbl && ((cmd.category == CAT_PRESSED) || (cmd.category == CAT_RELEASED))) begin
				for (int i = 0; i < TABLE_SLOTS; i++) begin
					if (sel_oh[i]) begin
						held_q[i] <= (cmd.category == CAT_PRESSED) ? cmd.key : cfg.empty_code;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ocat_q  <= ld_cat;
			okey_q  <= ld_key;
			orep_q  <= ld_rep;
			omod_q  <= mask_q;
			olast_q <= ld_last;
		end
	end

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("pop from empty queue");

	a_busy_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> cmd_valid && cmd.is_mod)
		else $error("replay running without a modifier command");

	a_fwd_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FWD) && out_free |=> ovalid_q && olast_q && !orep_q)
		else $error("forwarded event not marked last");

	a_replay_idx: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("slot index out of range");

endmodule
`default_nettype wire
